// ===== sv/lefi_pkg.sv =====
package lefi_pkg;

  // geometry of the filter
  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 4096;
  localparam int RADIUS      = 5;
  localparam int SPAN        = 2 * RADIUS + 1;
  localparam int STORE_DEPTH = SPAN * MAX_WIDTH;
  localparam int WIN_AREA    = SPAN * SPAN;

  // derived widths
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int CNT_W  = $clog2(WIN_AREA + 1);
  localparam int SPAN_W = $clog2(SPAN + 1);
  localparam int RAD_W  = $clog2(RADIUS + 1);
  localparam int WID_W  = 11;
  localparam int HGT_W  = 13;
  localparam int POS_W  = 23;
  localparam int LG_W   = 23;
  localparam int SUM_W  = 30;
  localparam int QUO_W  = 31;
  localparam int BINS   = 256;

  localparam logic [WID_W-1:0] WIDTH_RESET  = 11'd1024;
  localparam logic [HGT_W-1:0] HEIGHT_RESET = 13'd1024;

  // register indexes
  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_t;

  // input word kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] pixel_value;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  entropy_value;
    logic [9:0]  out_x;
    logic [11:0] out_y;
    logic        frame_last;
  } out_word_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_RD,
    S_HRD,
    S_HWR,
    S_DIV,
    S_MUL1,
    S_MUL2,
    S_OUT
  } state_t;

  typedef logic [SUM_W-1:0] flg_tab_t [0:WIN_AREA];

  // log2 in unsigned q3.20 by repeated squaring of the mantissa
  function automatic logic [LG_W-1:0] log2_q20(input int unsigned v);
    int unsigned      k;
    int               b;
    logic [63:0]      m;
    logic [LG_W-1:0]  r;
    k = 0;
    if (v <= 1) return '0;
    while (k < 31 && (v >> (k + 1)) != 0) k++;
    m = (64'(v) << 30) >> k;
    r = LG_W'(k << 20);
    for (b = 19; b >= 0; b--) begin
      m = (m * m) >> 30;
      if (m >= 64'h8000_0000) begin
        r[b] = 1'b1;
        m = m >> 1;
      end
    end
    return r;
  endfunction

  // table of k * log2(k) in q10.20
  function automatic flg_tab_t build_flg();
    flg_tab_t    t;
    logic [63:0] p;
    for (int k = 0; k <= WIN_AREA; k++) begin
      p = 64'(k) * 64'(log2_q20(k));
      t[k] = p[SUM_W-1:0];
    end
    return t;
  endfunction

  localparam flg_tab_t FLG_TABLE = build_flg();

endpackage

// ===== sv/lefi_ram.sv =====
module lefi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/local_entropy_image_filter_top.sv =====
// a word that releases no result is done once S_CHECK finds its window
//   incomplete; a released result (N window pixels, up to 121; a one-pixel
//   window skips the divide) waits on the histogram read-modify-write, S_RD,
//   S_HRD and S_HWR a pixel, once to build and once to empty the histogram,
//   then the divider and two multiplies
// one word at a time, the next taken in the cycle after the result is
//   loaded, later while a result waits
// reset: synchronous; a clearing pass zeroes all 256 histogram bins
module local_entropy_image_filter_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lefi_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lefi_pkg::out_word_t  out_data,
  input  logic                 cfg_write,
  input  logic [0:0]           cfg_index,
  input  logic [12:0]          cfg_data
);
  import lefi_pkg::*;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);
  localparam logic [ADDR_W:0]   DEPTH_X   = (ADDR_W + 1)'(STORE_DEPTH);

  state_t state, state_next;

  logic [WID_W-1:0]  width_reg;
  logic [HGT_W-1:0]  height_reg;
  logic [POS_W-1:0]  ip;
  logic [ADDR_W-1:0] in_addr;
  logic [9:0]        ox;
  logic [11:0]       oy;
  logic [ADDR_W-1:0] o_addr;
  logic              build;
  logic [ADDR_W-1:0] scan_start;
  logic [ADDR_W-1:0] row_start;
  logic [ADDR_W-1:0] cur_addr;
  logic [SPAN_W-1:0] cols;
  logic [SPAN_W-1:0] rows;
  logic [SPAN_W-1:0] col_left;
  logic [SPAN_W-1:0] row_left;
  logic [7:0]        bin;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  d_val;
  logic [SUM_W-1:0]  e_val;
  logic [QUO_W-1:0]  rem;
  logic [QUO_W-1:0]  quo;
  logic [4:0]        div_cnt;
  logic [QUO_W-1:0]  p2;
  logic [7:0]        res;
  logic [7:0]        clr_cnt;

  logic [7:0]        line_q;
  logic [CNT_W-1:0]  hist_q;
  logic              line_wr_en;
  logic              hist_wr_en;
  logic [7:0]        hist_wr_addr;
  logic [CNT_W-1:0]  hist_wr_data;

  // effective frame size
  logic [WID_W-1:0]  w_eff;
  logic [HGT_W-1:0]  h_eff;
  logic [POS_W-1:0]  total;
  logic [23:0]       total_full;
  logic              in_take;
  logic              pix_store;

  always_comb begin
    if (width_reg == '0) w_eff = WID_W'(1);
    else if (width_reg > WID_W'(MAX_WIDTH)) w_eff = WID_W'(MAX_WIDTH);
    else w_eff = width_reg;
    if (height_reg == '0) h_eff = HGT_W'(1);
    else if (height_reg > HGT_W'(MAX_HEIGHT)) h_eff = HGT_W'(MAX_HEIGHT);
    else h_eff = height_reg;
    total_full = 24'(w_eff) * 24'(h_eff);
    total      = total_full[POS_W-1:0];
  end

  assign in_take   = in_valid && in_ready;
  assign pix_store = in_take && (in_data.kind == KIND_PIXEL) && (ip < total);

  // window of the next output pixel
  logic [11:0]       ylo;
  logic [12:0]       yhi;
  logic [12:0]       oy_up;
  logic [9:0]        xlo;
  logic [10:0]       xhi;
  logic [10:0]       ox_up;
  logic [RAD_W-1:0]  dy;
  logic [RAD_W-1:0]  dx;
  logic [SPAN_W-1:0] rows_c;
  logic [SPAN_W-1:0] cols_c;
  logic [23:0]       needed;
  logic              win_ready;
  logic [ADDR_W:0]   back_off;
  logic [ADDR_W:0]   start_raw;
  logic [ADDR_W-1:0] start_c;
  logic [7:0]        n_full;
  logic [CNT_W-1:0]  n_c;

  always_comb begin
    ylo    = (oy >= 12'(RADIUS)) ? oy - 12'(RADIUS) : '0;
    oy_up  = 13'(oy) + 13'(RADIUS);
    yhi    = (oy_up < h_eff) ? oy_up : h_eff - 13'd1;
    xlo    = (ox >= 10'(RADIUS)) ? ox - 10'(RADIUS) : '0;
    ox_up  = 11'(ox) + 11'(RADIUS);
    xhi    = (ox_up < w_eff) ? ox_up : w_eff - 11'd1;
    dy     = RAD_W'(oy - ylo);
    dx     = RAD_W'(ox - xlo);
    rows_c = SPAN_W'(yhi - 13'(ylo) + 13'd1);
    cols_c = SPAN_W'(xhi - 11'(xlo) + 11'd1);
    needed = 24'(yhi) * 24'(w_eff) + 24'(xhi);
    win_ready = needed < 24'(ip);
    back_off  = (ADDR_W + 1)'(dy) * (ADDR_W + 1)'(w_eff) + (ADDR_W + 1)'(dx);
    start_raw = (ADDR_W + 1)'(o_addr) + DEPTH_X - back_off;
    start_c   = (start_raw >= DEPTH_X) ? ADDR_W'(start_raw - DEPTH_X)
                                       : start_raw[ADDR_W-1:0];
    n_full = 8'(rows_c) * 8'(cols_c);
    n_c    = n_full[CNT_W-1:0];
  end

  // histogram update and scan stepping
  logic [CNT_W-1:0]  cnt_new;
  logic [SUM_W-1:0]  sum_next;
  logic [SUM_W-1:0]  e_next;
  logic              col_last;
  logic              scan_end;
  logic [ADDR_W:0]   row_raw;
  logic [ADDR_W-1:0] row_next;
  logic [ADDR_W-1:0] cur_next;

  always_comb begin
    cnt_new  = build ? hist_q + CNT_W'(1) : hist_q - CNT_W'(1);
    sum_next = sum + FLG_TABLE[cnt_new] - FLG_TABLE[hist_q];
    e_next   = (d_val >= sum_next) ? d_val - sum_next : '0;
    col_last = col_left == SPAN_W'(1);
    scan_end = col_last && (row_left == SPAN_W'(1));
    row_raw  = (ADDR_W + 1)'(row_start) + (ADDR_W + 1)'(w_eff);
    row_next = (row_raw >= DEPTH_X) ? ADDR_W'(row_raw - DEPTH_X)
                                    : row_raw[ADDR_W-1:0];
    cur_next = (cur_addr == LAST_ADDR) ? '0 : cur_addr + ADDR_W'(1);
  end

  // divider step and products
  logic [QUO_W-1:0] rem_sub;
  logic             q_bit;
  logic [61:0]      qq;
  logic [38:0]      vv;

  always_comb begin
    q_bit   = rem >= QUO_W'(d_val);
    rem_sub = q_bit ? rem - QUO_W'(d_val) : rem;
    qq      = 62'(quo) * 62'(quo);
    vv      = 39'(p2) * 39'd255;
  end

  // output position stepping
  logic              row_end;
  logic              frame_end;
  logic              out_load;

  assign row_end   = 11'(ox) == w_eff - 11'd1;
  assign frame_end = row_end && (13'(oy) == h_eff - 13'd1);
  assign out_load  = (state == S_OUT) && (!out_valid || out_ready);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_cnt == 8'hFF) state_next = S_IDLE;
      S_IDLE:  if (in_valid) state_next = S_CHECK;
      S_CHECK: state_next = win_ready ? S_RD : S_IDLE;
      S_RD:    state_next = S_HRD;
      S_HRD:   state_next = S_HWR;
      S_HWR: begin
        if (!scan_end) state_next = S_RD;
        else if (build) state_next = S_RD;
        else if (d_val == '0) state_next = S_OUT;
        else state_next = S_DIV;
      end
      S_DIV:   if (div_cnt == '0) state_next = S_MUL1;
      S_MUL1:  state_next = S_MUL2;
      S_MUL2:  state_next = S_OUT;
      S_OUT:   if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  // memory controls and handshake
  always_comb begin
    in_ready     = state == S_IDLE;
    line_wr_en   = pix_store;
    hist_wr_en   = (state == S_CLEAR) || (state == S_HWR);
    hist_wr_addr = (state == S_CLEAR) ? clr_cnt : bin;
    hist_wr_data = (state == S_CLEAR) ? '0 : cnt_new;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      width_reg  <= WIDTH_RESET;
      height_reg <= HEIGHT_RESET;
      ip         <= '0;
      in_addr    <= '0;
      ox         <= '0;
      oy         <= '0;
      o_addr     <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + 8'd1;
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;

      if (cfg_write) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_WIDTH:  width_reg  <= cfg_data[WID_W-1:0];
          REG_HEIGHT: height_reg <= cfg_data;
        endcase
        ip      <= '0;
        in_addr <= '0;
        ox      <= '0;
        oy      <= '0;
        o_addr  <= '0;
      end else if (pix_store) begin
        ip      <= ip + POS_W'(1);
        in_addr <= (in_addr == LAST_ADDR) ? '0 : in_addr + ADDR_W'(1);
      end else if (out_load) begin
        if (frame_end) begin
          ip      <= '0;
          in_addr <= '0;
          ox      <= '0;
          oy      <= '0;
          o_addr  <= '0;
        end else begin
          o_addr <= (o_addr == LAST_ADDR) ? '0 : o_addr + ADDR_W'(1);
          if (row_end) begin
            ox <= '0;
            oy <= oy + 12'd1;
          end else begin
            ox <= ox + 10'd1;
          end
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_CHECK: begin
        build      <= 1'b1;
        scan_start <= start_c;
        row_start  <= start_c;
        cur_addr   <= start_c;
        rows       <= rows_c;
        cols       <= cols_c;
        row_left   <= rows_c;
        col_left   <= cols_c;
        sum        <= '0;
        d_val      <= FLG_TABLE[n_c];
      end
      S_HRD: bin <= line_q;
      S_HWR: begin
        sum <= sum_next;
        if (scan_end) begin
          if (build) e_val <= e_next;
          build     <= 1'b0;
          row_start <= scan_start;
          cur_addr  <= scan_start;
          row_left  <= rows;
          col_left  <= cols;
          rem       <= QUO_W'(e_val);
          quo       <= '0;
          div_cnt   <= 5'(QUO_W - 1);
          res       <= '0;
        end else if (col_last) begin
          row_start <= row_next;
          cur_addr  <= row_next;
          row_left  <= row_left - SPAN_W'(1);
          col_left  <= cols;
        end else begin
          cur_addr <= cur_next;
          col_left <= col_left - SPAN_W'(1);
        end
      end
      S_DIV: begin
        quo     <= {quo[QUO_W-2:0], q_bit};
        rem     <= {rem_sub[QUO_W-2:0], 1'b0};
        div_cnt <= div_cnt - 5'd1;
      end
      S_MUL1: p2 <= qq[60:30];
      S_MUL2: res <= (vv[38:30] > 9'd255) ? 8'd255 : vv[37:30];
      default: ;
    endcase
    if (out_load) begin
      out_data.entropy_value <= res;
      out_data.out_x         <= ox;
      out_data.out_y         <= oy;
      out_data.frame_last    <= frame_end;
    end
  end

  // line store, eleven rows deep
  lefi_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_line (
    .clk     (clk),
    .wr_en   (line_wr_en),
    .wr_addr (in_addr),
    .wr_data (in_data.pixel_value),
    .rd_addr (cur_addr),
    .rd_data (line_q)
  );

  // window histogram
  lefi_ram #(.WIDTH(CNT_W), .DEPTH(BINS)) u_hist (
    .clk     (clk),
    .wr_en   (hist_wr_en),
    .wr_addr (hist_wr_addr),
    .wr_data (hist_wr_data),
    .rd_addr (line_q),
    .rd_data (hist_q)
  );

endmodule

// ===== sv/lefi_checker.sv =====
module lefi_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input lefi_pkg::out_word_t out_data
);
  import lefi_pkg::*;

  // reset empties the output and starts the histogram clearing pass
  a_reset: assert property (@(posedge clk) rst |=> !out_valid && !in_ready)
    else $error("output or input side live right after reset");

  // a word is processed before the next one is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again in the cycle after a word");

  // a waiting result is held
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");

endmodule

bind local_entropy_image_filter_top lefi_checker u_lefi_checker (.*);
